// ----- sv/acig_pkg.sv -----
`timescale 1ns / 1ps

package acig_pkg;

    // alignment state codes
    localparam logic [2:0] CODE_MATCH    = 3'd0;
    localparam logic [2:0] CODE_MISMATCH = 3'd1;
    localparam logic [2:0] CODE_N_LOWER  = 3'd2;
    localparam logic [2:0] CODE_N_UPPER  = 3'd3;
    localparam logic [2:0] CODE_INS      = 3'd4;
    localparam logic [2:0] CODE_DEL      = 3'd5;

    // cigar ops
    localparam logic [1:0] OP_M = 2'd0;
    localparam logic [1:0] OP_I = 2'd1;
    localparam logic [1:0] OP_D = 2'd2;
    localparam logic [1:0] OP_S = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_RUN      = 2'd0;
    localparam logic [1:0] KIND_MISMATCH = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_FAIL     = 2'd3;

    // config register indexes
    localparam logic [1:0] REG_CLIP_MODE     = 2'd0;
    localparam logic [1:0] REG_MAX_KEPT      = 2'd1;
    localparam logic [1:0] REG_CLIP_BOUNDARY = 2'd2;
    localparam logic [1:0] REG_READ_LENGTH   = 2'd3;

    localparam int NRES = 5;  // most results one item can cause
    localparam int NBUF = 6;  // output buffer slots

    typedef struct packed {
        logic       clip_mode;
        logic [7:0] max_kept_mismatches;
        logic [7:0] clip_boundary;
        logic [7:0] read_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] count_or_pos;
        logic [1:0] op;
        logic [7:0] entry_byte;
        logic       cigar_empty;
        logic       end_of_run;
    } result_t;

    typedef struct packed {
        result_t [NRES-1:0] ent;
        logic [2:0]         n;
    } rbuf_t;

    function automatic result_t mk_result(logic [1:0] kind, logic [7:0] cp, logic [1:0] op,
                                          logic [7:0] byte_v, logic empty, logic eor);
        result_t r;
        r.kind         = kind;
        r.count_or_pos = cp;
        r.op           = op;
        r.entry_byte   = byte_v;
        r.cigar_empty  = empty;
        r.end_of_run   = eor;
        return r;
    endfunction

    function automatic rbuf_t put_res(rbuf_t b, result_t r);
        rbuf_t o;
        o = b;
        if (o.n < 3'(NRES))
        begin
            o.ent[o.n] = r;
            o.n        = o.n + 3'd1;
        end
        return o;
    endfunction

endpackage

// ----- sv/acig_core.sv -----
`timescale 1ns / 1ps

module acig_core #(
    parameter int CIGAR_ENTRIES    = 32,
    parameter int MISMATCH_ENTRIES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [2:0]           code,
    input  logic [7:0]           base,
    input  logic                 last,
    input  acig_pkg::cfg_t       cfg,
    output acig_pkg::rbuf_t      res
);

    localparam int CW = $clog2(CIGAR_ENTRIES + 2);
    localparam int MW = $clog2(MISMATCH_ENTRIES + 1);
    localparam logic [CW-1:0] CE_FULL = CW'(CIGAR_ENTRIES);
    localparam logic [CW-1:0] CE_CLIP = CW'(CIGAR_ENTRIES - 2);
    localparam logic [MW-1:0] ME_FULL = MW'(MISMATCH_ENTRIES);

    typedef struct packed {
        logic            held_valid;
        logic [7:0]      held_count;
        logic [1:0]      held_op;
        logic [CW-1:0]   cw;
        acig_pkg::rbuf_t rb;
    } emit_t;

    // first run is held back until a second one exists
    function automatic emit_t emit_run(emit_t e, logic [8:0] count, logic [1:0] op);
        emit_t o;
        o = e;
        if (o.cw == '0)
        begin
            o.held_valid = 1'b1;
            o.held_count = count[7:0];
            o.held_op    = op;
        end
        else
        begin
            if (o.held_valid)
            begin
                o.rb = acig_pkg::put_res(o.rb, acig_pkg::mk_result(acig_pkg::KIND_RUN,
                           o.held_count, o.held_op, 8'd0, 1'b0, 1'b0));
                o.held_valid = 1'b0;
            end
            o.rb = acig_pkg::put_res(o.rb, acig_pkg::mk_result(acig_pkg::KIND_RUN,
                       count[7:0], op, 8'd0, 1'b0, 1'b0));
        end
        o.cw = o.cw + CW'(1);
        return o;
    endfunction

    logic [1:0]    prev_op_reg, prev_op_next;
    logic [8:0]    run_count_reg, run_count_next;
    logic [7:0]    read_pos_reg, read_pos_next;
    logic [CW-1:0] cigar_reg, cigar_next;
    logic [MW-1:0] mism_reg, mism_next;
    logic [7:0]    kept_reg, kept_next;
    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_count_reg, held_count_next;
    logic [1:0]    held_op_reg, held_op_next;
    logic          first_reg, first_next;
    logic          stopped_reg, stopped_next;

    always_comb
    begin
        emit_t      e;
        logic [1:0] cls;
        logic [8:0] old_count;
        logic       changed;
        logic       fin;
        logic       ok;
        logic       clip;
        logic       clr;
        logic       is_entry;

        e.held_valid = held_valid_reg;
        e.held_count = held_count_reg;
        e.held_op    = held_op_reg;
        e.cw         = cigar_reg;
        e.rb         = '0;
        prev_op_next   = prev_op_reg;
        run_count_next = run_count_reg;
        read_pos_next  = read_pos_reg;
        mism_next      = mism_reg;
        kept_next      = kept_reg;
        first_next     = first_reg;
        stopped_next   = stopped_reg;
        fin       = 1'b0;
        ok        = 1'b0;
        clip      = 1'b0;
        clr       = 1'b0;
        changed   = 1'b0;
        old_count = run_count_reg;
        is_entry  = (code >= acig_pkg::CODE_MISMATCH) && (code <= acig_pkg::CODE_INS);
        cls = (code == acig_pkg::CODE_INS) ? acig_pkg::OP_I :
              ((code == acig_pkg::CODE_DEL) ? acig_pkg::OP_D : acig_pkg::OP_M);

        if (stopped_reg)
        begin
            clr = last;
        end
        else
        begin
            if (first_reg)
            begin
                prev_op_next   = cls;
                run_count_next = 9'd0;
                first_next     = 1'b0;
            end
            old_count = run_count_next;

            if (!cfg.clip_mode)
            begin
                if (code > acig_pkg::CODE_DEL)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    if (is_entry)
                    begin
                        if (mism_next >= ME_FULL)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            e.rb = acig_pkg::put_res(e.rb, acig_pkg::mk_result(
                                       acig_pkg::KIND_MISMATCH, read_pos_next,
                                       acig_pkg::OP_M, base, 1'b0, 1'b0));
                            mism_next = mism_next + MW'(1);
                        end
                    end
                    if (!fin)
                    begin
                        if (cls != acig_pkg::OP_D)
                            read_pos_next = read_pos_next + 8'd1;
                        if (cls != prev_op_next)
                        begin
                            if (e.cw >= CE_FULL || run_count_next[8])
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                e = emit_run(e, run_count_next, prev_op_next);
                                prev_op_next   = cls;
                                run_count_next = 9'd1;
                            end
                        end
                        else if (!run_count_next[8])
                        begin
                            run_count_next = run_count_next + 9'd1;
                        end
                        if (!fin && last)
                        begin
                            fin = 1'b1;
                            if (!(e.cw >= CE_FULL || run_count_next[8]))
                            begin
                                e  = emit_run(e, run_count_next, prev_op_next);
                                ok = 1'b1;
                            end
                        end
                    end
                end
            end
            else
            begin
                if (cls != prev_op_next)
                begin
                    if (e.cw >= CE_CLIP)
                    begin
                        if (read_pos_next >= cfg.clip_boundary)
                            clip = 1'b1;
                        else
                            fin = 1'b1;
                    end
                    else if (run_count_next[8])
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        e = emit_run(e, run_count_next, prev_op_next);
                        prev_op_next   = cls;
                        run_count_next = 9'd1;
                        changed        = 1'b1;
                    end
                end
                else if (!run_count_next[8])
                begin
                    run_count_next = run_count_next + 9'd1;
                end

                if (!fin && !clip && code == acig_pkg::CODE_MISMATCH)
                begin
                    if ({1'b0, kept_next} + 9'd1 > {1'b0, cfg.max_kept_mismatches})
                    begin
                        run_count_next = changed ? 9'd0 : old_count;
                        clip = 1'b1;
                    end
                    else
                    begin
                        kept_next = kept_next + 8'd1;
                    end
                end

                if (!fin && !clip)
                begin
                    if (is_entry)
                    begin
                        if (mism_next >= ME_FULL)
                        begin
                            if (read_pos_next >= cfg.clip_boundary)
                            begin
                                run_count_next = changed ? 9'd0 : old_count;
                                clip = 1'b1;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        else
                        begin
                            e.rb = acig_pkg::put_res(e.rb, acig_pkg::mk_result(
                                       acig_pkg::KIND_MISMATCH, read_pos_next,
                                       acig_pkg::OP_M, base, 1'b0, 1'b0));
                            mism_next = mism_next + MW'(1);
                        end
                    end
                    else if (code > acig_pkg::CODE_DEL)
                    begin
                        fin = 1'b1;
                    end
                end

                if (!fin && !clip)
                begin
                    if (cls != acig_pkg::OP_D)
                        read_pos_next = read_pos_next + 8'd1;
                    fin = last;
                end

                if (clip)
                begin
                    if (run_count_next != 9'd0 && prev_op_next != acig_pkg::OP_D)
                    begin
                        if (e.cw >= CE_FULL || run_count_next[8])
                            fin = 1'b1;
                        else
                            e = emit_run(e, run_count_next, prev_op_next);
                    end
                    if (!fin)
                    begin
                        fin = 1'b1;
                        if (read_pos_next < cfg.read_length)
                        begin
                            e  = emit_run(e, {1'b0, cfg.read_length - read_pos_next},
                                          acig_pkg::OP_S);
                            ok = 1'b1;
                        end
                    end
                end
            end

            if (fin)
            begin
                if (ok)
                    e.rb = acig_pkg::put_res(e.rb, acig_pkg::mk_result(acig_pkg::KIND_DONE,
                               8'd0, acig_pkg::OP_M, 8'd0, (e.cw <= CW'(1)), 1'b1));
                else
                    e.rb = acig_pkg::put_res(e.rb, acig_pkg::mk_result(acig_pkg::KIND_FAIL,
                               8'd0, acig_pkg::OP_M, 8'd0, 1'b0, 1'b1));
                clr = 1'b1;
            end
        end

        held_valid_next = e.held_valid;
        held_count_next = e.held_count;
        held_op_next    = e.held_op;
        cigar_next      = e.cw;
        if (clr)
        begin
            prev_op_next    = acig_pkg::OP_M;
            run_count_next  = 9'd0;
            read_pos_next   = 8'd0;
            cigar_next      = '0;
            mism_next       = '0;
            kept_next       = 8'd0;
            held_valid_next = 1'b0;
            held_count_next = 8'd0;
            held_op_next    = acig_pkg::OP_M;
            first_next      = 1'b1;
            stopped_next    = fin && !last;
        end
        res = e.rb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_op_reg    <= acig_pkg::OP_M;
            run_count_reg  <= 9'd0;
            read_pos_reg   <= 8'd0;
            cigar_reg      <= '0;
            mism_reg       <= '0;
            kept_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
            held_count_reg <= 8'd0;
            held_op_reg    <= acig_pkg::OP_M;
            first_reg      <= 1'b1;
            stopped_reg    <= 1'b0;
        end
        else if (step)
        begin
            prev_op_reg    <= prev_op_next;
            run_count_reg  <= run_count_next;
            read_pos_reg   <= read_pos_next;
            cigar_reg      <= cigar_next;
            mism_reg       <= mism_next;
            kept_reg       <= kept_next;
            held_valid_reg <= held_valid_next;
            held_count_reg <= held_count_next;
            held_op_reg    <= held_op_next;
            first_reg      <= first_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

// ----- sv/acig_outbuf.sv -----
`timescale 1ns / 1ps

module acig_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  acig_pkg::rbuf_t   rb,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output acig_pkg::result_t out_res
);

    acig_pkg::result_t [acig_pkg::NBUF-1:0] slot_reg, slot_next;
    logic [2:0] cnt_reg, cnt_next;

    logic pop;
    logic [2:0] base_cnt;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = slot_reg[0];
    assign room      = (cnt_reg <= 3'd1);
    assign pop       = out_valid && out_ready;
    assign base_cnt  = pop ? (cnt_reg - 3'd1) : cnt_reg;

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = base_cnt;
        if (pop)
        begin
            for (int i = 0; i < acig_pkg::NBUF - 1; i++)
                slot_next[i] = slot_reg[i+1];
        end
        if (load)
        begin
            // room guarantees base_cnt is 0 or 1
            if (base_cnt == 3'd0)
            begin
                for (int i = 0; i < acig_pkg::NRES; i++)
                    slot_next[i] = rb.ent[i];
            end
            else
            begin
                for (int i = 0; i < acig_pkg::NRES; i++)
                    slot_next[i+1] = rb.ent[i];
            end
            cnt_next = base_cnt + rb.n;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

// ----- sv/alignment_cigar_encoder.sv -----
`timescale 1ns / 1ps
// CIGAR run-length encoder for a stream of per-base alignment states.
// Slave channel: one item per base, tdata = {base, state_code}, tlast marks
// the final state of an alignment. Master channel: result items, tuser = kind
// (run, mismatch entry, done, failed), tlast on done/failed.
// Config: cfg_we/cfg_index/cfg_data write clip_mode, max_kept_mismatches,
// clip_boundary, read_length (indexes 0..3); write only while idle.
// An accepted item is encoded while it sits in the input register and
// is loaded into the output buffer once the buffer has room; its results
// then show on the master side from the head of the buffer.
// Throughput: one item per cycle while each item gives at most one result and
// m_tready stays high; after an item giving k results the next item waits in
// the input register until the output buffer drains to one entry, so the rate
// is set by the master side, one result per cycle (up to five results per item).
// Reset clears the alignment state, the buffer and config to defaults
// (mode 0, 8 kept mismatches, boundary 0, read length 100).
// A master-side stall holds results in the six-entry buffer; once it holds
// two or more results an item in the input register waits and s_tready drops.
module alignment_cigar_encoder #(
    parameter int CIGAR_ENTRIES    = 32,
    parameter int MISMATCH_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] state_code, [10:3] base, zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] count_or_pos, [9:8] op,
                                   // [17:10] entry_byte, [18] cigar_empty, pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    acig_pkg::cfg_t    cfg_reg;
    acig_pkg::rbuf_t   rb;
    acig_pkg::result_t out_res;

    logic       in_valid_reg;
    logic [2:0] in_code_reg;
    logic [7:0] in_base_reg;
    logic       in_last_reg;
    logic       room;
    logic       step;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_mode           <= 1'b0;
            cfg_reg.max_kept_mismatches <= 8'd8;
            cfg_reg.clip_boundary       <= 8'd0;
            cfg_reg.read_length         <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acig_pkg::REG_CLIP_MODE:     cfg_reg.clip_mode           <= cfg_data[0];
                acig_pkg::REG_MAX_KEPT:      cfg_reg.max_kept_mismatches <= cfg_data;
                acig_pkg::REG_CLIP_BOUNDARY: cfg_reg.clip_boundary       <= cfg_data;
                acig_pkg::REG_READ_LENGTH:   cfg_reg.read_length         <= cfg_data;
                default:                     cfg_reg.clip_mode           <= cfg_reg.clip_mode;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_code_reg <= s_tdata[2:0];
            in_base_reg <= s_tdata[10:3];
            in_last_reg <= s_tlast;
        end
    end

    acig_core #(
        .CIGAR_ENTRIES    (CIGAR_ENTRIES),
        .MISMATCH_ENTRIES (MISMATCH_ENTRIES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .code  (in_code_reg),
        .base  (in_base_reg),
        .last  (in_last_reg),
        .cfg   (cfg_reg),
        .res   (rb)
    );

    acig_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .rb        (rb),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.cigar_empty, out_res.entry_byte, out_res.op,
                      out_res.count_or_pos};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.end_of_run;

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == acig_pkg::KIND_DONE ||
                                 m_tuser == acig_pkg::KIND_FAIL))
        else $error("end_of_run on a non-final result");

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == acig_pkg::KIND_DONE || m_tuser == acig_pkg::KIND_FAIL)
        |-> m_tlast)
        else $error("done/failed without end_of_run");

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_code_reg) &&
                                  $stable(in_last_reg))
        else $error("blocked input item lost");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input not ready with empty input register");

endmodule

// ----- test/alignment_cigar_encoder_tb.sv -----
`timescale 1ns / 1ps

module alignment_cigar_encoder_tb;

    localparam int CIGAR_ENTRIES    = 32;
    localparam int MISMATCH_ENTRIES = 32;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int RANDOM_ITEMS     = 200;

    localparam logic [2:0] CODE_INVALID = 3'd6;
    localparam logic [2:0] CODE_SPARE   = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [2:0] state_code, [10:3] base, pad
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [7:0] count_or_pos, [9:8] op,
                                   // [17:10] entry_byte, [18] cigar_empty, pad
    logic [1:0]  m_tuser;          // kind
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    alignment_cigar_encoder #(
        .CIGAR_ENTRIES    (CIGAR_ENTRIES),
        .MISMATCH_ENTRIES (MISMATCH_ENTRIES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // encoder model state
    acig_pkg::cfg_t cfg;
    logic [1:0]     prev_op;
    int             run_count;
    logic [7:0]     read_pos;
    int             cigar_written;
    int             mismatch_written;
    int             kept_count;
    bit             held_valid;
    logic [7:0]     held_count;
    logic [1:0]     held_op;
    bit             first_item;
    bit             stopped;

    acig_pkg::result_t expected_results[$];

    int cycle_count = 0;
    int error_count = 0;
    int rx_wait     = 0;
    int hold_cycles = 0;
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_alignment();
        prev_op          = acig_pkg::OP_M;
        run_count        = 0;
        read_pos         = '0;
        cigar_written    = 0;
        mismatch_written = 0;
        kept_count       = 0;
        held_valid       = 1'b0;
        held_count       = '0;
        held_op          = acig_pkg::OP_M;
        first_item       = 1'b1;
        stopped          = 1'b0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] cp, logic [1:0] op,
                                       logic [7:0] entry, logic empty, logic eor);
        acig_pkg::result_t r;
        r.kind         = kind;
        r.count_or_pos = cp;
        r.op           = op;
        r.entry_byte   = entry;
        r.cigar_empty  = empty;
        r.end_of_run   = eor;
        expected_results.push_back(r);
    endfunction

    // first run is held back until a second one exists
    function automatic void close_run(int count, logic [1:0] op);
        if (cigar_written == 0)
        begin
            held_valid = 1'b1;
            held_count = 8'(count);
            held_op    = op;
        end
        else
        begin
            if (held_valid)
            begin
                add_result(acig_pkg::KIND_RUN, held_count, held_op, '0, 1'b0, 1'b0);
                held_valid = 1'b0;
            end
            add_result(acig_pkg::KIND_RUN, 8'(count), op, '0, 1'b0, 1'b0);
        end
        cigar_written++;
    endfunction

    function automatic void end_alignment(bit ok, logic last);
        if (ok)
            add_result(acig_pkg::KIND_DONE, '0, '0, '0, cigar_written <= 1, 1'b1);
        else
            add_result(acig_pkg::KIND_FAIL, '0, '0, '0, 1'b0, 1'b1);
        clear_alignment();
        if (!last)
            stopped = 1'b1;
    endfunction

    function automatic bit has_entry(logic [2:0] code);
        return code == acig_pkg::CODE_MISMATCH || code == acig_pkg::CODE_N_LOWER ||
               code == acig_pkg::CODE_N_UPPER || code == acig_pkg::CODE_INS;
    endfunction

    function automatic void encode_item(logic [2:0] code, logic [7:0] base, logic last);
        logic [1:0] cls;
        int         old_count;
        bit         changed;
        bit         do_clip;

        cls = code == acig_pkg::CODE_INS ? acig_pkg::OP_I :
              (code == acig_pkg::CODE_DEL ? acig_pkg::OP_D : acig_pkg::OP_M);
        if (stopped)
        begin
            if (last)
                clear_alignment();
            return;
        end
        if (first_item)
        begin
            prev_op    = cls;
            run_count  = 0;
            first_item = 1'b0;
        end

        if (cfg.clip_mode == 1'b0)
        begin
            if (code > acig_pkg::CODE_DEL)
            begin
                end_alignment(1'b0, last);
                return;
            end
            if (has_entry(code))
            begin
                if (mismatch_written >= MISMATCH_ENTRIES)
                begin
                    end_alignment(1'b0, last);
                    return;
                end
                add_result(acig_pkg::KIND_MISMATCH, read_pos, '0, base, 1'b0, 1'b0);
                mismatch_written++;
            end
            if (cls != acig_pkg::OP_D)
                read_pos = read_pos + 8'd1;
            if (cls != prev_op)
            begin
                if (cigar_written >= CIGAR_ENTRIES || run_count > 255)
                begin
                    end_alignment(1'b0, last);
                    return;
                end
                close_run(run_count, prev_op);
                prev_op   = cls;
                run_count = 1;
            end
            else if (run_count < 256)
                run_count++;
            if (!last)
                return;
            if (cigar_written >= CIGAR_ENTRIES || run_count > 255)
            begin
                end_alignment(1'b0, last);
                return;
            end
            close_run(run_count, prev_op);
            end_alignment(1'b1, last);
            return;
        end

        // soft clip mode
        old_count = run_count;
        changed   = 1'b0;
        do_clip   = 1'b0;
        if (cls != prev_op)
        begin
            if (cigar_written >= CIGAR_ENTRIES - 2)
            begin
                if (read_pos >= cfg.clip_boundary)
                    do_clip = 1'b1;
                else
                begin
                    end_alignment(1'b0, last);
                    return;
                end
            end
            else if (run_count > 255)
            begin
                end_alignment(1'b0, last);
                return;
            end
            else
            begin
                close_run(run_count, prev_op);
                prev_op   = cls;
                run_count = 1;
                changed   = 1'b1;
            end
        end
        else if (run_count < 256)
            run_count++;

        if (!do_clip && code == acig_pkg::CODE_MISMATCH)
        begin
            if (kept_count + 1 > int'(cfg.max_kept_mismatches))
            begin
                run_count = changed ? 0 : old_count;
                do_clip   = 1'b1;
            end
            else
                kept_count++;
        end
        if (!do_clip)
        begin
            if (has_entry(code))
            begin
                if (mismatch_written >= MISMATCH_ENTRIES)
                begin
                    if (read_pos >= cfg.clip_boundary)
                    begin
                        run_count = changed ? 0 : old_count;
                        do_clip   = 1'b1;
                    end
                    else
                    begin
                        end_alignment(1'b0, last);
                        return;
                    end
                end
                else
                begin
                    add_result(acig_pkg::KIND_MISMATCH, read_pos, '0, base, 1'b0, 1'b0);
                    mismatch_written++;
                end
            end
            else if (code > acig_pkg::CODE_DEL)
            begin
                end_alignment(1'b0, last);
                return;
            end
        end
        if (!do_clip)
        begin
            if (cls != acig_pkg::OP_D)
                read_pos = read_pos + 8'd1;
            if (last)
                end_alignment(1'b0, last);
            return;
        end

        // tail clip: close the open run, then the S run
        if (run_count > 0 && prev_op != acig_pkg::OP_D)
        begin
            if (cigar_written >= CIGAR_ENTRIES || run_count > 255)
            begin
                end_alignment(1'b0, last);
                return;
            end
            close_run(run_count, prev_op);
        end
        if (read_pos >= cfg.read_length)
        begin
            end_alignment(1'b0, last);
            return;
        end
        close_run(int'(cfg.read_length) - int'(read_pos), acig_pkg::OP_S);
        end_alignment(1'b1, last);
    endfunction

    // ------------------------------------------------------------ checking

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 100)
            $display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    endtask

    // m_tready: long hold-off first, then the per-item wait
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // outputs only move at posedge, so negedge values are the accepted ones
    always @(negedge clk)
    begin : check_result
        acig_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
            if (expected_results.size() == 0)
                report_mismatch("result with none expected, kind", m_tuser, -1);
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[7:0] != want.count_or_pos)
                    report_mismatch("count_or_pos", m_tdata[7:0], want.count_or_pos);
                if (m_tdata[9:8] != want.op)
                    report_mismatch("op", m_tdata[9:8], want.op);
                if (m_tdata[17:10] != want.entry_byte)
                    report_mismatch("entry_byte", m_tdata[17:10], want.entry_byte);
                if (m_tdata[18] != want.cigar_empty)
                    report_mismatch("cigar_empty", m_tdata[18], want.cigar_empty);
                if (m_tlast != want.end_of_run)
                    report_mismatch("end_of_run", m_tlast, want.end_of_run);
            end
        end
    end

    // ------------------------------------------------------------- driving

    task automatic send_item(input logic [2:0] code, input logic [7:0] base,
                             input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, base, code};
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        encode_item(code, base, last);
    endtask

    task automatic send_run(input logic [2:0] code, input int count);
        for (int i = 0; i < count; i++)
            send_item(code, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            acig_pkg::REG_CLIP_MODE:     cfg.clip_mode           = value[0];
            acig_pkg::REG_MAX_KEPT:      cfg.max_kept_mismatches = value;
            acig_pkg::REG_CLIP_BOUNDARY: cfg.clip_boundary       = value;
            default:                     cfg.read_length         = value;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic [7:0] kept,
                              input logic [7:0] boundary, input logic [7:0] length);
        write_reg(acig_pkg::REG_CLIP_MODE, {7'b0, mode});
        write_reg(acig_pkg::REG_MAX_KEPT, kept);
        write_reg(acig_pkg::REG_CLIP_BOUNDARY, boundary);
        write_reg(acig_pkg::REG_READ_LENGTH, length);
    endtask

    function automatic logic [2:0] random_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)      return acig_pkg::CODE_MATCH;
        else if (r < 60) return acig_pkg::CODE_MISMATCH;
        else if (r < 66) return acig_pkg::CODE_N_LOWER;
        else if (r < 72) return acig_pkg::CODE_N_UPPER;
        else if (r < 84) return acig_pkg::CODE_INS;
        else if (r < 96) return acig_pkg::CODE_DEL;
        else if (r < 98) return CODE_INVALID;
        else             return CODE_SPARE;
    endfunction

    // --------------------------------------------------------------- tests

    task automatic test_mode0_directed();
        send_item(acig_pkg::CODE_MATCH, 8'h00, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'hFF, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'hA5, 1'b1);
        send_item(acig_pkg::CODE_MATCH, 8'h01, 1'b0);
        send_item(acig_pkg::CODE_MISMATCH, 8'hFF, 1'b0);
        send_item(acig_pkg::CODE_N_LOWER, 8'h6E, 1'b0);
        send_item(acig_pkg::CODE_N_UPPER, 8'h4E, 1'b0);
        send_item(acig_pkg::CODE_INS, 8'hAA, 1'b0);
        send_item(acig_pkg::CODE_INS, 8'h55, 1'b0);
        send_item(acig_pkg::CODE_DEL, 8'h00, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h80, 1'b1);
        // invalid code stops the alignment until the next last
        send_item(CODE_INVALID, 8'h7F, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h12, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h34, 1'b1);
        send_item(acig_pkg::CODE_DEL, 8'h00, 1'b0);
        send_item(acig_pkg::CODE_DEL, 8'hFF, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h3C, 1'b1);
        send_item(CODE_SPARE, 8'hC3, 1'b1);
        wait_idle();
    endtask

    task automatic test_clip_directed();
        set_config(1'b1, 8'd1, 8'd0, 8'd10);
        send_item(acig_pkg::CODE_MATCH, 8'h11, 1'b0);
        send_item(acig_pkg::CODE_MISMATCH, 8'h22, 1'b0);
        send_item(acig_pkg::CODE_INS, 8'h33, 1'b0);
        send_item(acig_pkg::CODE_MISMATCH, 8'h44, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h55, 1'b1);
        // mode 1 alignment ending without a clip
        send_item(acig_pkg::CODE_MATCH, 8'h66, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h77, 1'b1);
        wait_idle();
        set_config(1'b1, 8'd0, 8'd0, 8'd1);
        send_item(acig_pkg::CODE_MISMATCH, 8'h88, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h99, 1'b1);
        // clip at the read end
        send_item(acig_pkg::CODE_MATCH, 8'hAA, 1'b0);
        send_item(acig_pkg::CODE_MISMATCH, 8'hBB, 1'b1);
        wait_idle();
        set_config(1'b1, 8'd255, 8'd255, 8'd255);
        send_item(acig_pkg::CODE_MATCH, 8'hCC, 1'b0);
        send_item(CODE_INVALID, 8'hDD, 1'b1);
        wait_idle();
    endtask

    task automatic test_long_runs();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_config(1'b0, 8'd8, 8'd0, 8'd100);
        // run count saturates, read position wraps before the mismatch,
        // closing run too long
        send_run(acig_pkg::CODE_MATCH, 256);
        send_item(acig_pkg::CODE_MISMATCH, 8'h03, 1'b0);
        send_item(acig_pkg::CODE_MATCH, 8'h04, 1'b1);
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic send_alternating(input logic [2:0] first_code, input logic [2:0] other,
                                    input int count);
        for (int i = 1; i <= count; i++)
            send_item(i % 2 ? first_code : other, 8'($urandom_range(0, 255)), i == count);
    endtask

    task automatic test_list_overflow();
        set_config(1'b0, 8'd8, 8'd0, 8'd100);
        send_run(acig_pkg::CODE_MISMATCH, 32);
        send_item(acig_pkg::CODE_MISMATCH, 8'hE1, 1'b1);
        send_alternating(acig_pkg::CODE_MATCH, acig_pkg::CODE_DEL, 34);
        wait_idle();
        set_config(1'b1, 8'd255, 8'd255, 8'd255);
        send_alternating(acig_pkg::CODE_MATCH, acig_pkg::CODE_DEL, 32);
        send_run(acig_pkg::CODE_N_UPPER, 32);
        send_item(acig_pkg::CODE_N_LOWER, 8'hE2, 1'b1);
        wait_idle();
        write_reg(acig_pkg::REG_CLIP_BOUNDARY, 8'd0);
        send_alternating(acig_pkg::CODE_MATCH, acig_pkg::CODE_DEL, 32);
        send_alternating(acig_pkg::CODE_DEL, acig_pkg::CODE_MATCH, 32);
        send_run(acig_pkg::CODE_N_UPPER, 32);
        send_item(acig_pkg::CODE_N_LOWER, 8'hE3, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(1'b0, 8'd8, 8'd0, 8'd100);
        tx_idle     = 1'b0;
        hold_cycles = 300;
        for (int i = 1; i <= 40; i++)
            send_item(i % 2 ? acig_pkg::CODE_MISMATCH : acig_pkg::CODE_INS,
                      8'($urandom_range(0, 255)), i == 40);
        wait_idle();
        tx_idle = 1'b1;
    endtask

    task automatic randomize_config();
        logic [7:0] kept;
        logic [7:0] boundary;
        logic [7:0] length;
        kept     = $urandom_range(0, 9) == 0 ? 8'd255 : 8'($urandom_range(0, 4));
        boundary = $urandom_range(0, 9) == 0 ? 8'd255 : 8'($urandom_range(0, 20));
        length   = $urandom_range(0, 9) == 0 ? 8'd255 : 8'($urandom_range(1, 30));
        set_config(1'($urandom_range(0, 1)), kept, boundary, length);
    endtask

    task automatic test_random();
        int sent;
        int len;
        int split;
        logic last;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                randomize_config();
            end
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            len     = $urandom_range(1, 16);
            split   = $urandom_range(0, 7) == 0 ? $urandom_range(1, len) : 0;
            for (int i = 1; i <= len; i++)
            begin
                if (i == split)
                begin
                    // mode change in the middle of an alignment
                    wait_idle();
                    write_reg(acig_pkg::REG_CLIP_MODE, {7'b0, ~cfg.clip_mode});
                end
                last = i == len || $urandom_range(0, 19) == 0;
                if (!stopped)
                    sent++;
                send_item(random_code(), 8'($urandom_range(0, 255)), last);
            end
        end
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        cfg.clip_mode           = 1'b0;
        cfg.max_kept_mismatches = 8'd8;
        cfg.clip_boundary       = 8'd0;
        cfg.read_length         = 8'd100;
        clear_alignment();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_mode0_directed();
        test_clip_directed();
        test_long_runs();
        test_list_overflow();
        test_backpressure();
        test_random();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- alignment_cigar_encoder.f -----
sv/acig_pkg.sv
sv/acig_core.sv
sv/acig_outbuf.sv
sv/alignment_cigar_encoder.sv
test/alignment_cigar_encoder_tb.sv
